// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RMF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmf assertion failed");

// next-cycle implication
`define RMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmf assertion failed");

`endif

// ===== hdl/rmf_pkg.sv =====
// running median filter package: widths, constants, fsm state, command and status types
// no dependencies
`timescale 1ns / 1ps

package rmf_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int LEN_W          = 4;
  localparam int LEN_MAX        = 15;
  localparam int MAX_WINDOW_DEF = 15;

  localparam logic [SAMPLE_W-1:0] SIGN_BIAS = 32'h8000_0000;
  localparam logic [SAMPLE_W-1:0] KEY_PAD   = 32'hFFFF_FFFF;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SAMPLE_W-1:0]        key_t;
  typedef logic [LEN_W-1:0]           len_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LAST,
    S_DONE
  } rmf_state_t;

  typedef struct packed {
    logic start;
    logic read_en;
    logic load_out;
  } rmf_cmd_t;

  typedef struct packed {
    logic last_read;
    logic out_busy;
  } rmf_status_t;

endpackage

// ===== hdl/rmf_if.sv =====
// channel interfaces of the running median filter: samples, results, config writes
// depends on rmf_pkg
`timescale 1ns / 1ps

interface rmf_in_if;
  logic             valid;
  logic             ready;
  rmf_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface rmf_out_if;
  logic             valid;
  logic             ready;
  rmf_pkg::sample_t median_out;
  logic             length_error;

  modport source (output valid, output median_out, output length_error, input ready);
  modport sink (input valid, input median_out, input length_error, output ready);
endinterface

interface rmf_cfg_if;
  logic          valid;
  logic          ready;
  rmf_pkg::len_t window_length;

  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

// ===== hdl/rmf_ctrl.sv =====
// running median filter controller: sequences write, history read-out and result load
// depends on rmf_pkg
`timescale 1ns / 1ps

module rmf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rmf_pkg::rmf_status_t status,
  output rmf_pkg::rmf_cmd_t    cmd,
  output rmf_pkg::rmf_state_t  state
);
  import rmf_pkg::*;

  rmf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        if (status.last_read) state_next = S_LAST;
      end
      S_LAST: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!status.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.read_en  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_READ: begin
        cmd.read_en = 1'b1;
      end
      S_LAST: begin
      end
      S_DONE: begin
        cmd.load_out = !status.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/rmf_datapath.sv =====
// running median filter datapath: config register, history memory,
// insertion-sort cell row and output register; depends on rmf_pkg
`timescale 1ns / 1ps

module rmf_datapath #(
  parameter int MAX_WINDOW = rmf_pkg::MAX_WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rmf_pkg::sample_t     sample_in,
  input  logic                 cfg_valid,
  input  rmf_pkg::len_t        cfg_data,
  input  rmf_pkg::rmf_cmd_t    cmd,
  output rmf_pkg::rmf_status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output rmf_pkg::sample_t     median_out,
  output logic                 length_error
);
  import rmf_pkg::*;

  localparam int SORT_N  = (MAX_WINDOW < LEN_MAX) ? MAX_WINDOW : LEN_MAX;
  localparam int HIST_AW = $clog2(SORT_N);
  localparam int SIDX_W  = $clog2(SORT_N);

  logic [SAMPLE_W-1:0] hist [SORT_N];

  len_t window_length;
  len_t fill;
  len_t slot;
  len_t rd_idx;
  logic rd_valid;
  key_t rd_data;
  logic err;
  key_t row [SORT_N];
  key_t row_next [SORT_N];

  len_t eff_len;
  len_t fill_c;
  len_t slot_c;
  len_t slot_inc;
  logic err_c;
  key_t key;

  always_comb begin
    if (window_length == '0) begin
      eff_len = len_t'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      eff_len = len_t'(MAX_WINDOW);
    end else begin
      eff_len = window_length;
    end
    fill_c   = (fill > eff_len) ? eff_len : fill;
    slot_c   = (slot >= eff_len) ? '0 : slot;
    slot_inc = slot_c + len_t'(1);
    err_c    = (int'(window_length) > MAX_WINDOW) || !window_length[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= len_t'(1);
    end else if (cfg_valid) begin
      window_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      slot     <= '0;
      rd_idx   <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.read_en;
      if (cmd.start) begin
        fill   <= (fill_c < eff_len) ? fill_c + len_t'(1) : fill_c;
        slot   <= (slot_inc >= eff_len) ? '0 : slot_inc;
        rd_idx <= '0;
      end else if (cmd.read_en) begin
        rd_idx <= rd_idx + len_t'(1);
      end
    end
  end

  // history memory, one write and one registered read per cycle
  // cleared at reset so slots not yet written read as zero after the window grows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SORT_N; i++) begin
        hist[i] <= '0;
      end
    end else if (cmd.start) begin
      hist[HIST_AW'(slot_c)] <= sample_in;
    end
    if (cmd.read_en) begin
      rd_data <= hist[HIST_AW'(rd_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) err <= err_c;
  end

  assign status.last_read = (rd_idx == fill - len_t'(1));

  // biased keys compare unsigned in signed order
  assign key = rd_data ^ SIGN_BIAS;

  // each cell keeps, takes the new key, or takes its left neighbor; cell 0 only keeps or takes the key
  always_comb begin
    row_next[0] = (row[0] <= key) ? row[0] : key;
  end

  for (genvar i = 1; i < SORT_N; i++) begin : g_cell
    always_comb begin
      if (row[i] <= key) begin
        row_next[i] = row[i];
      end else if (row[i-1] <= key) begin
        row_next[i] = key;
      end else begin
        row_next[i] = row[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SORT_N; i++) begin
      if (cmd.start) begin
        row[i] <= KEY_PAD;
      end else if (rd_valid) begin
        row[i] <= row_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      median_out   <= sample_t'(row[SIDX_W'(fill >> 1)] ^ SIGN_BIAS);
      length_error <= err;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== hdl/running_median_filter_top.sv =====
// running median filter top level: channels, controller and datapath
// depends on rmf_pkg, rmf_if, rmf_ctrl, rmf_datapath and assert_macros.svh
//
// usage:
//   samples carries one signed 32-bit sample per request; results carries the
//   median of the samples held in the window and a length_error flag.
//   cfg_wr writes window_length; it is always ready and is meant to be used
//   only while no sample is in flight.
// sequence:
//   an accepted sample is written to the history memory, which then gives
//   one sample a cycle to the insertion-sort cell row; the median is then
//   loaded into the output register, and the next sample is taken only
//   after that load.
// reset:
//   rst (synchronous, active high) empties the window, restarts the write
//   slot at zero and sets window_length back to 1.
// stall:
//   the result sits in an output register until taken; a new sample is
//   accepted and processed meanwhile, and its result waits behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module running_median_filter_top #(
  parameter int MAX_WINDOW = rmf_pkg::MAX_WINDOW_DEF
) (
  input logic       clk,
  input logic       rst,
  rmf_in_if.sink    samples,
  rmf_out_if.source results,
  rmf_cfg_if.sink   cfg_wr
);
  import rmf_pkg::*;

  rmf_cmd_t    cmd;
  rmf_status_t status;
  rmf_state_t  state;

  assign cfg_wr.ready = 1'b1;

  rmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  rmf_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .sample_in    (samples.sample_in),
    .cfg_valid    (cfg_wr.valid),
    .cfg_data     (cfg_wr.window_length),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (results.ready),
    .out_valid    (results.valid),
    .median_out   (results.median_out),
    .length_error (results.length_error)
  );

  // an accepted request keeps the block busy on the next cycle
  `RMF_ASSERT_NEXT(a_busy_after_accept, clk, rst, samples.valid && samples.ready, !samples.ready)

  // a result only appears after the done state
  `RMF_ASSERT_NEXT(a_result_from_done, clk, rst, !results.valid && state != S_DONE, !results.valid)

  // the median is only loaded once the last history read has been sorted in
  `RMF_ASSERT_NEXT(a_load_after_last, clk, rst, cmd.read_en && status.last_read, !cmd.load_out)

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking bench for running_median_filter_top: random and directed samples, window changes
// predicts each median and length_error flag in step with accepted requests
// depends on rmf_pkg, rmf_if and the filter rtl
`timescale 1ns / 1ps

module tb_top;
  import rmf_pkg::*;

  localparam int MAX_WIN = MAX_WINDOW_DEF;
  localparam int SAMPLE_TOTAL = 1300;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    sample_t median;
    logic    len_err;
  } median_exp_t;

  logic clk;
  logic rst;

  rmf_in_if  in_ch();
  rmf_out_if out_ch();
  rmf_cfg_if cfg_ch();

  running_median_filter_top dut (
    .clk    (clk),
    .rst    (rst),
    .samples(in_ch),
    .results(out_ch),
    .cfg_wr (cfg_ch)
  );

  // expected behavior of the filter
  sample_t hist [MAX_WIN];
  int      fill_cnt;
  int      wr_slot;
  len_t    win_len;

  sample_t     sample_q[$];
  median_exp_t median_q[$];

  int  send_gap;
  int  recv_gap;
  int  send_mode;
  int  recv_mode;
  bit  req_taken;
  bit  hold_active;
  int  accepted_cnt;
  int  mismatch_cnt;
  int  queued_cnt;
  sample_t     prev_sample;
  median_exp_t got;
  median_exp_t want;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void push_sample(input sample_t s, output sample_t med,
                                      output logic err);
    sample_t keys [MAX_WIN];
    sample_t k;
    int      eff;
    int      n;
    int      j;
    eff = (win_len == 0) ? 1 : ((win_len > MAX_WIN) ? MAX_WIN : int'(win_len));
    // a shrunk window clamps the count and may restart the write slot
    if (fill_cnt > eff) fill_cnt = eff;
    if (wr_slot >= eff) wr_slot = 0;
    hist[wr_slot] = s;
    wr_slot++;
    if (wr_slot >= eff) wr_slot = 0;
    if (fill_cnt < eff) fill_cnt++;
    n = fill_cnt;
    for (int i = 0; i < n; i++) keys[i] = hist[i];
    for (int i = 1; i < n; i++) begin
      k = keys[i];
      j = i;
      while (j > 0 && keys[j-1] > k) begin
        keys[j] = keys[j-1];
        j--;
      end
      keys[j] = k;
    end
    med = keys[n/2];
    err = (win_len > MAX_WIN) || (win_len[0] == 1'b0);
  endfunction

  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (mode == 2) return $urandom_range(10, 40);
    return $urandom_range(4, 6);
  endfunction

  function automatic sample_t gen_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return sample_t'($urandom);
    if (r < 8) return sample_t'($signed($urandom_range(0, 16)) - 8);
    if (r == 8) begin
      case ($urandom_range(0, 5))
        0: return sample_t'(32'h8000_0000);
        1: return sample_t'(32'h7FFF_FFFF);
        2: return sample_t'(32'h8000_0001);
        3: return sample_t'(32'h7FFF_FFFE);
        4: return sample_t'(32'hFFFF_FFFF);
        default: return sample_t'(0);
      endcase
    end
    return prev_sample + sample_t'($signed($urandom_range(0, 6)) - 3);
  endfunction

  task automatic note_mismatch(input string what, input median_exp_t e,
                               input median_exp_t a);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t mismatch (%s): expected median %0d err %0b, got median %0d err %0b",
               $time, what, e.median, e.len_err, a.median, a.len_err);
  endtask

  // sample requests; valid holds until taken
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !req_taken) begin
      in_ch.valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (sample_q.size() > 0) begin
      in_ch.valid <= 1'b1;
      in_ch.sample_in <= sample_q.pop_front();
    end else begin
      in_ch.valid <= 1'b0;
    end
    req_taken = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst || hold_active) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap = recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) win_len = cfg_ch.window_length;
      if (in_ch.valid && in_ch.ready) begin
        push_sample(in_ch.sample_in, want.median, want.len_err);
        median_q.push_back(want);
        req_taken = 1'b1;
        send_gap = pick_gap(send_mode);
        accepted_cnt++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.median = out_ch.median_out;
        got.len_err = out_ch.length_error;
        recv_gap = pick_gap(recv_mode);
        if (median_q.size() == 0) begin
          want.median = 'x;
          want.len_err = 'x;
          note_mismatch("unexpected result", want, got);
        end else begin
          want = median_q.pop_front();
          if (got.median !== want.median || got.len_err !== want.len_err)
            note_mismatch("result", want, got);
        end
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (sample_q.size() != 0 || in_ch.valid || median_q.size() != 0);
  endtask

  task automatic write_len(input len_t v);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.window_length <= v;
    do @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_sample(input sample_t s);
    sample_q.push_back(s);
    prev_sample = s;
    queued_cnt++;
  endtask

  // long result stall while samples keep coming, so the filter backs up
  initial begin
    hold_active = 1'b0;
    for (int k = 0; k < 2; k++) begin
      do @(posedge clk);
      while (!(accepted_cnt >= 200 + 500 * k && sample_q.size() > 10));
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  initial begin
    #1_500_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    len_t lens [5] = '{4'd15, 4'd0, 4'd1, 4'd14, 4'd2};
    int   n;
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.window_length = '0;
    for (int i = 0; i < MAX_WIN; i++) hist[i] = '0;
    fill_cnt = 0;
    wr_slot = 0;
    win_len = 4'd1;
    send_gap = 0;
    recv_gap = 0;
    send_mode = 1;
    recv_mode = 1;
    req_taken = 1'b0;
    accepted_cnt = 0;
    mismatch_cnt = 0;
    queued_cnt = 0;
    prev_sample = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // length 1 out of reset: extremes pass straight through
    queue_sample(sample_t'(32'h8000_0000));
    queue_sample(sample_t'(32'h7FFF_FFFF));
    queue_sample(sample_t'(0));
    queue_sample(sample_t'(-1));
    // zero length acts as one, flagged
    write_len(4'd0);
    queue_sample(sample_t'(5));
    queue_sample(sample_t'(-5));
    // full window, warm-up through even counts
    write_len(4'd15);
    queue_sample(sample_t'(32'h8000_0000));
    queue_sample(sample_t'(32'h7FFF_FFFF));
    queue_sample(sample_t'(0));
    queue_sample(sample_t'(-1));
    queue_sample(sample_t'(1));
    queue_sample(sample_t'(2));
    queue_sample(sample_t'(-2));
    queue_sample(sample_t'(3));
    // shrink with the write slot past the new end
    write_len(4'd3);
    queue_sample(sample_t'(100));
    queue_sample(sample_t'(-100));
    queue_sample(sample_t'(7));
    // even length, flagged but still filtering
    write_len(4'd4);
    queue_sample(sample_t'(9));
    queue_sample(sample_t'(-9));
    queue_sample(sample_t'(4));
    write_len(4'd7);
    queue_sample(sample_t'(32'h8000_0001));
    queue_sample(sample_t'(32'h7FFF_FFFE));
    queue_sample(sample_t'(0));

    for (int p = 0; queued_cnt < SAMPLE_TOTAL; p++) begin
      wait_idle();
      send_mode = $urandom_range(0, 2);
      recv_mode = $urandom_range(0, 2);
      write_len((p < 5) ? lens[p] : len_t'($urandom_range(0, 15)));
      // some short runs so the window changes during warm-up
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : $urandom_range(20, 80);
      for (int i = 0; i < n; i++) queue_sample(gen_sample());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && median_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
